[src/mtkf_pkg.sv]
// Shared types, constants and fixed-point helpers for the multi-track Kalman filter.
package mtkf_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_TRACKS = 256;
	localparam int IDX_W      = $clog2(MAX_TRACKS);
	localparam int REG_W      = 17;

	localparam logic [REG_W-1:0] REG_RESET = REG_W'(6554);
	localparam logic signed [31:0] FX_ONE  = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] FX_MAX  = 32'sh7fffffff;
	localparam logic signed [31:0] FX_MIN  = 32'sh80000000;

	// register indexes on the config port
	localparam logic [1:0] REG_TIME_STEP     = 2'd0;
	localparam logic [1:0] REG_PROCESS_NOISE = 2'd1;
	localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

	typedef struct packed {
		logic [7:0]         track_id;
		logic signed [31:0] meas_x;
		logic signed [31:0] meas_y;
		logic signed [31:0] meas_z;
	} meas_item_t;

	typedef struct packed {
		logic [7:0]         out_id;
		logic signed [31:0] est_px;
		logic signed [31:0] est_py;
		logic signed [31:0] est_pz;
		logic signed [31:0] est_vx;
		logic signed [31:0] est_vy;
		logic signed [31:0] est_vz;
	} est_item_t;

	// one track record as held in the state memory
	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic [31:0]      pp;
		logic [31:0]      pv;
		logic [31:0]      vv;
	} track_rec_t;

	function automatic logic signed [31:0] fx_sat(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh000000007fffffff)
			r = FX_MAX;
		else if (v < -64'sh0000000080000000)
			r = FX_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [63:0] sx64(input logic signed [31:0] a);
		return $signed({{32{a[31]}}, a});
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
	                                              input logic signed [31:0] b);
		return fx_sat(sx64(a) + sx64(b));
	endfunction

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
	                                              input logic signed [31:0] b);
		return fx_sat(sx64(a) - sx64(b));
	endfunction

	// round half up, floor shift, saturate
	function automatic logic signed [31:0] fx_round(input logic signed [63:0] prod);
		logic signed [63:0] t;
		t = prod + (64'sd1 <<< (FRAC_BITS - 1));
		return fx_sat(t >>> FRAC_BITS);
	endfunction

endpackage

[src/multi_track_kalman_filter.sv]
// Multi-track constant-velocity Kalman filter, top level.
//
//  channel | direction | handshake              | payload
//  meas    | in        | meas_valid/meas_stall  | meas (meas_item_t)
//  est     | out       | est_valid/est_stall    | est  (est_item_t)
//  cfg     | in        | cfg_we                 | cfg_idx, cfg_data
//
// One item at a time: it is taken, its track record is loaded, six of the 15 multiplies
// run on the single 32x32 multiplier, two gain divides follow (setup, 49 restoring
// steps, fix-up), then the other nine multiplies, write-back and output load; the input
// stalls until the estimate is loaded. A non-positive innovation variance skips the divides.
// Reset clears the track valid bits and loads the default registers;
// the record memory needs no clearing, a fresh track is built from constants.
// A finished estimate sits in the output register; the next item is taken
// while it waits, and only its own hand-off waits for est_stall to drop.
module multi_track_kalman_filter import mtkf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             meas_valid,
	output logic             meas_stall,
	input  meas_item_t       meas,
	output logic             est_valid,
	input  logic             est_stall,
	output est_item_t        est,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [REG_W-1:0] cfg_data
);

	localparam int NUM_W = 33 + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_ISSUE, S_MWAIT, S_APPLY, S_DIVI, S_DIV, S_DIVF, S_WB, S_PUT
	} state_t;

	// multiply schedule; the three gain-covariance steps keep predicted pv last
	typedef enum logic [3:0] {
		U_T1, U_M, U_T2, U_PX, U_PY, U_PZ, U_CX, U_CY, U_CZ,
		U_VX, U_VY, U_VZ, U_PP, U_VV, U_PV
	} uop_t;

	state_t state_q;
	uop_t   uop_q;

	logic [REG_W-1:0] dt_q, qn_q, rn_q;

	// track memory and valid bits
	track_rec_t mem [MAX_TRACKS];
	track_rec_t rd_q;
	logic [MAX_TRACKS-1:0] tvalid_q;
	logic       was_valid_q;
	logic       mem_we;
	logic [IDX_W-1:0] idx_q;
	logic [7:0] id_q;

	// working registers
	logic signed [31:0] p_q [3];
	logic signed [31:0] v_q [3];
	logic signed [31:0] z_q [3];
	logic signed [31:0] e_q [3];
	logic signed [31:0] pp_q, pv_q, vv_q, t1_q, m_q, s_q, k1_q, k2_q;

	// multiplier
	logic signed [31:0] mul_a_q, mul_b_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] mr;

	// divider
	logic [NUM_W-1:0] num_q;
	logic [32:0]      rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q, div_sel_q;

	logic signed [31:0] sel_a, sel_b, pp_n, s_n, pn, dn, kq;
	logic signed [31:0] dtx, qx, rx;
	logic [32:0] nx, mag, rs;
	logic        ge;
	logic [1:0]  ax;
	track_rec_t  wr_rec;

	assign dtx = $signed({{(32-REG_W){1'b0}}, dt_q});
	assign qx  = $signed({{(32-REG_W){1'b0}}, qn_q});
	assign rx  = $signed({{(32-REG_W){1'b0}}, rn_q});
	assign mr  = fx_round(prod_q);

	assign meas_stall = (state_q != S_IDLE);
	assign mem_we     = (state_q == S_WB);

	always_comb begin
		unique case (uop_q)
			U_PY, U_CY, U_VY: ax = 2'd1;
			U_PZ, U_CZ, U_VZ: ax = 2'd2;
			default:          ax = 2'd0;
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		unique case (uop_q)
			U_T1:               begin sel_a = dtx;  sel_b = pv_q;    end
			U_M:                begin sel_a = dtx;  sel_b = vv_q;    end
			U_T2:               begin sel_a = dtx;  sel_b = m_q;     end
			U_PX, U_PY, U_PZ:   begin sel_a = dtx;  sel_b = v_q[ax]; end
			U_CX, U_CY, U_CZ:   begin sel_a = k1_q; sel_b = e_q[ax]; end
			U_VX, U_VY, U_VZ:   begin sel_a = k2_q; sel_b = e_q[ax]; end
			U_PP:               begin sel_a = k1_q; sel_b = pp_q;    end
			U_VV:               begin sel_a = k2_q; sel_b = pv_q;    end
			U_PV:               begin sel_a = k1_q; sel_b = pv_q;    end
			default:            begin sel_a = dtx;  sel_b = pv_q;    end
		endcase
	end

	// predicted pp, innovation variance and updated position
	always_comb begin
		pp_n = fx_sat(sx64(pp_q) + (sx64(t1_q) <<< 1) + sx64(mr) + sx64(qx));
		s_n  = add_sat(pp_n, rx);
		pn   = add_sat(p_q[ax], mr);
	end

	// divider step and quotient fix-up
	always_comb begin
		dn  = div_sel_q ? pv_q : pp_q;
		nx  = {dn[31], dn};
		mag = dn[31] ? (~nx + 33'd1) : nx;
		rs  = {rem_q[31:0], num_q[NUM_W-1]};
		ge  = (rs >= {1'b0, s_q});
		if (neg_q) begin
			if ((|num_q[NUM_W-1:32]) || (num_q[31] && (|num_q[30:0])))
				kq = FX_MIN;
			else
				kq = $signed(~num_q[31:0] + 32'd1);
		end else begin
			if (|num_q[NUM_W-1:31])
				kq = FX_MAX;
			else
				kq = $signed(num_q[31:0]);
		end
	end

	always_comb begin
		wr_rec.pos[0] = p_q[0];
		wr_rec.pos[1] = p_q[1];
		wr_rec.pos[2] = p_q[2];
		wr_rec.vel[0] = v_q[0];
		wr_rec.vel[1] = v_q[1];
		wr_rec.vel[2] = v_q[2];
		wr_rec.pp     = pp_q;
		wr_rec.pv     = pv_q;
		wr_rec.vv     = vv_q;
	end

	// record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[idx_q] <= wr_rec;
		if (meas_valid && !meas_stall)
			rd_q <= mem[meas.track_id[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= REG_RESET;
			qn_q <= REG_RESET;
			rn_q <= REG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TIME_STEP:     dt_q <= cfg_data;
				REG_PROCESS_NOISE: qn_q <= cfg_data;
				REG_MEASURE_NOISE: rn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tvalid_q <= '0;
		else if (mem_we)
			tvalid_q[idx_q] <= 1'b1;
	end

	// payload path of the sequencer
	always_ff @(posedge clk) begin
		prod_q <= mul_a_q * mul_b_q;
		unique case (state_q)
			S_IDLE: begin
				if (meas_valid) begin
					id_q        <= meas.track_id;
					idx_q       <= meas.track_id[IDX_W-1:0];
					was_valid_q <= tvalid_q[meas.track_id[IDX_W-1:0]];
					z_q[0]      <= meas.meas_x;
					z_q[1]      <= meas.meas_y;
					z_q[2]      <= meas.meas_z;
				end
			end
			S_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					p_q[i] <= was_valid_q ? $signed(rd_q.pos[i]) : 32'sd0;
					v_q[i] <= was_valid_q ? $signed(rd_q.vel[i]) : 32'sd0;
				end
				pp_q <= was_valid_q ? $signed(rd_q.pp) : FX_ONE;
				pv_q <= was_valid_q ? $signed(rd_q.pv) : 32'sd0;
				vv_q <= was_valid_q ? $signed(rd_q.vv) : FX_ONE;
			end
			S_ISSUE: begin
				mul_a_q <= sel_a;
				mul_b_q <= sel_b;
			end
			S_APPLY: begin
				unique case (uop_q)
					U_T1: t1_q <= mr;
					U_M:  m_q  <= mr;
					U_T2: begin
						pp_q <= pp_n;
						pv_q <= add_sat(pv_q, m_q);
						vv_q <= add_sat(vv_q, qx);
						s_q  <= s_n;
					end
					U_PX, U_PY, U_PZ: begin
						p_q[ax] <= pn;
						e_q[ax] <= sub_sat(z_q[ax], pn);
					end
					U_CX, U_CY, U_CZ: p_q[ax] <= pn;
					U_VX, U_VY, U_VZ: v_q[ax] <= add_sat(v_q[ax], mr);
					U_PP: pp_q <= sub_sat(pp_q, mr);
					U_VV: vv_q <= sub_sat(vv_q, mr);
					U_PV: pv_q <= sub_sat(pv_q, mr);
					default: ;
				endcase
			end
			S_DIVI: begin
				if (s_q <= 32'sd0) begin
					// no usable innovation variance: zero gains
					k1_q <= 32'sd0;
					k2_q <= 32'sd0;
				end
				num_q <= {mag, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				cnt_q <= CNT_W'(NUM_W - 1);
				neg_q <= dn[31];
			end
			S_DIV: begin
				rem_q <= ge ? (rs - {1'b0, s_q}) : rs;
				num_q <= {num_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_DIVF: begin
				if (div_sel_q)
					k2_q <= kq;
				else
					k1_q <= kq;
			end
			default: ;
		endcase
	end

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			uop_q     <= U_T1;
			div_sel_q <= 1'b0;
			est_valid <= 1'b0;
			est       <= '0;
		end else begin
			// S_PUT reloads the output register itself
			if (est_valid && !est_stall && state_q != S_PUT)
				est_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (meas_valid) state_q <= S_LOAD;
				S_LOAD: begin
					uop_q   <= U_T1;
					state_q <= S_ISSUE;
				end
				S_ISSUE: state_q <= S_MWAIT;
				S_MWAIT: state_q <= S_APPLY;
				S_APPLY: begin
					if (uop_q == U_PZ) begin
						div_sel_q <= 1'b0;
						state_q   <= S_DIVI;
					end else if (uop_q == U_PV) begin
						state_q <= S_WB;
					end else begin
						uop_q   <= uop_t'(uop_q + 4'd1);
						state_q <= S_ISSUE;
					end
				end
				S_DIVI: begin
					if (s_q <= 32'sd0) begin
						uop_q   <= U_CX;
						state_q <= S_ISSUE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: if (cnt_q == '0) state_q <= S_DIVF;
				S_DIVF: begin
					if (div_sel_q) begin
						uop_q   <= U_CX;
						state_q <= S_ISSUE;
					end else begin
						div_sel_q <= 1'b1;
						state_q   <= S_DIVI;
					end
				end
				S_WB: state_q <= S_PUT;
				S_PUT: begin
					if (!est_valid || !est_stall) begin
						est_valid     <= 1'b1;
						est.out_id    <= id_q;
						est.est_px    <= p_q[0];
						est.est_py    <= p_q[1];
						est.est_pz    <= p_q[2];
						est.est_vx    <= v_q[0];
						est.est_vy    <= v_q[1];
						est.est_vz    <= v_q[2];
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/mtkf_checker.sv]
// Port-level checker for the multi-track Kalman filter, with its bind.
module mtkf_checker import mtkf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       meas_valid,
	input logic       meas_stall,
	input logic       est_valid,
	input logic       est_stall,
	input est_item_t  est
);

	// stalled estimate holds
	a_est_hold: assert property (@(posedge clk) disable iff (!arst_n)
		est_valid && est_stall |=> est_valid && $stable(est))
		else $error("stalled estimate changed");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && !meas_stall |=> meas_stall)
		else $error("second item taken while busy");

	// a new estimate only appears at the end of a busy period
	a_new_est: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(est_valid) |-> $past(meas_stall))
		else $error("estimate without an item in work");

endmodule

bind multi_track_kalman_filter mtkf_checker u_mtkf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.meas_valid (meas_valid),
	.meas_stall (meas_stall),
	.est_valid  (est_valid),
	.est_stall  (est_stall),
	.est        (est)
);

[verif/tb_top.sv]
// Testbench for the multi-track Kalman filter, checked against an in-bench filter.
`timescale 1ns / 100ps

module tb_top;
	import mtkf_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_WAIT  = 400;   // settling time after the last estimate is returned

	logic             clk;
	logic             arst_n;
	logic             meas_valid;
	logic             meas_stall;
	meas_item_t       meas;
	logic             est_valid;
	logic             est_stall;
	est_item_t        est;
	logic             cfg_we;
	logic [1:0]       cfg_idx;
	logic [REG_W-1:0] cfg_data;

	est_item_t est_q[$];              // estimates still owed by the block

	multi_track_kalman_filter u_top (
		.clk(clk), .arst_n(arst_n),
		.meas_valid(meas_valid), .meas_stall(meas_stall), .meas(meas),
		.est_valid(est_valid), .est_stall(est_stall), .est(est),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// ---------------------------------------------------------------
	// Clock, reset, cycle limit
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	int unsigned cycles;
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d estimates outstanding", cycles, est_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Filter state mirrored in the bench
	// ---------------------------------------------------------------
	int  flt_dt, flt_q, flt_r;        // register copies, 17-bit unsigned
	bit  trk_live [MAX_TRACKS];
	int  trk_pos  [MAX_TRACKS][3];
	int  trk_vel  [MAX_TRACKS][3];
	int  trk_pp   [MAX_TRACKS];
	int  trk_pv   [MAX_TRACKS];
	int  trk_vv   [MAX_TRACKS];

	function automatic int clamp32(longint v);
		if (v > 64'sh7fffffff)
			return 32'sh7fffffff;
		if (v < -64'sh80000000)
			return 32'sh80000000;
		return int'(v);
	endfunction

	// Q16.16 product, round half up, floor, saturate
	function automatic int qmul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC_BITS - 1));
		return clamp32(p >>> FRAC_BITS);
	endfunction

	// Q16.16 quotient truncated toward zero; no gain when s is not positive
	function automatic int qdiv(int n, int s);
		if (s <= 0)
			return 0;
		return clamp32((longint'(n) <<< FRAC_BITS) / longint'(s));
	endfunction

	// predict + update on one track, returns the filtered estimate
	function automatic est_item_t filter_track(meas_item_t m);
		est_item_t r;
		int t, pp, pv, vv, npp, npv, nvv, s, k1, k2, z, p, v, e;
		t = int'(m.track_id) % MAX_TRACKS;
		if (!trk_live[t]) begin
			for (int a = 0; a < 3; a++) begin
				trk_pos[t][a] = 0;
				trk_vel[t][a] = 0;
			end
			trk_pp[t] = 1 << FRAC_BITS;
			trk_pv[t] = 0;
			trk_vv[t] = 1 << FRAC_BITS;
			trk_live[t] = 1'b1;
		end
		pp = trk_pp[t];
		pv = trk_pv[t];
		vv = trk_vv[t];
		npp = clamp32(longint'(pp) + 2 * longint'(qmul(flt_dt, pv))
		              + longint'(qmul(flt_dt, qmul(flt_dt, vv))) + longint'(flt_q));
		npv = clamp32(longint'(pv) + longint'(qmul(flt_dt, vv)));
		nvv = clamp32(longint'(vv) + longint'(flt_q));
		pp = npp; pv = npv; vv = nvv;
		s  = clamp32(longint'(pp) + longint'(flt_r));
		k1 = qdiv(pp, s);
		k2 = qdiv(pv, s);
		r.out_id = m.track_id;
		for (int a = 0; a < 3; a++) begin
			z = (a == 0) ? m.meas_x : (a == 1) ? m.meas_y : m.meas_z;
			v = trk_vel[t][a];
			p = clamp32(longint'(trk_pos[t][a]) + longint'(qmul(flt_dt, v)));
			e = clamp32(longint'(z) - longint'(p));
			p = clamp32(longint'(p) + longint'(qmul(k1, e)));
			v = clamp32(longint'(v) + longint'(qmul(k2, e)));
			trk_pos[t][a] = p;
			trk_vel[t][a] = v;
			case (a)
				0: begin r.est_px = p; r.est_vx = v; end
				1: begin r.est_py = p; r.est_vy = v; end
				default: begin r.est_pz = p; r.est_vz = v; end
			endcase
		end
		trk_pp[t] = clamp32(longint'(pp) - longint'(qmul(k1, pp)));
		trk_pv[t] = clamp32(longint'(pv) - longint'(qmul(k1, pv)));
		trk_vv[t] = clamp32(longint'(vv) - longint'(qmul(k2, pv)));
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	bit meas_idle_en;   // random gaps between items
	bit est_stall_en;   // random back-pressure on the output
	int hold_cycles;    // forced output hold-off, counted down by the receiver
	int n_sent;

	task automatic send_meas(meas_item_t m);
		while (meas_idle_en && $urandom_range(99) < 32) begin
			meas_valid <= 1'b0;
			@(posedge clk);
		end
		meas_valid <= 1'b1;
		meas       <= m;
		do
			@(posedge clk);
		while (meas_stall);
		est_q.push_back(filter_track(m));
		n_sent++;
	endtask

	// wait for all owed estimates, then let the block settle
	task automatic drain();
		meas_valid <= 1'b0;
		@(posedge clk);
		while (est_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= REG_W'(value);
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TIME_STEP:     flt_dt = value & 32'h1ffff;
			REG_PROCESS_NOISE: flt_q  = value & 32'h1ffff;
			default:           flt_r  = value & 32'h1ffff;
		endcase
	endtask

	task automatic set_filter(int dt, int q, int r);
		write_reg(REG_TIME_STEP, dt);
		write_reg(REG_PROCESS_NOISE, q);
		write_reg(REG_MEASURE_NOISE, r);
	endtask

	function automatic meas_item_t mk_meas(int id, int x, int y, int z);
		meas_item_t m;
		m.track_id = 8'(id);
		m.meas_x = x;
		m.meas_y = y;
		m.meas_z = z;
		return m;
	endfunction

	// ---------------------------------------------------------------
	// Receiver side and checking
	// ---------------------------------------------------------------
	initial begin
		est_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				est_stall <= 1'b1;
				hold_cycles--;
			end else begin
				est_stall <= est_stall_en && ($urandom_range(99) < 32);
			end
		end
	end

	int n_checked, n_errors;

	always @(posedge clk) begin
		est_item_t want;
		if (arst_n && est_valid && !est_stall) begin
			n_checked++;
			if (est_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected estimate id %0d at cycle %0d", est.out_id, cycles);
			end else begin
				want = est_q.pop_front();
				if (est.out_id !== want.out_id || est.est_px !== want.est_px ||
				    est.est_py !== want.est_py || est.est_pz !== want.est_pz ||
				    est.est_vx !== want.est_vx || est.est_vy !== want.est_vy ||
				    est.est_vz !== want.est_vz) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("mismatch at cycle %0d", cycles);
						$display("  exp id %0d p %h %h %h v %h %h %h", want.out_id,
						         want.est_px, want.est_py, want.est_pz,
						         want.est_vx, want.est_vy, want.est_vz);
						$display("  got id %0d p %h %h %h v %h %h %h", est.out_id,
						         est.est_px, est.est_py, est.est_pz,
						         est.est_vx, est.est_vy, est.est_vz);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// field extremes, fresh tracks at both ends of the id range, repeats
	task automatic test_directed();
		send_meas(mk_meas(0, 0, 0, 0));
		send_meas(mk_meas(255, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		send_meas(mk_meas(255, 32'sh80000000, 32'sh7fffffff, 32'sh80000000));
		send_meas(mk_meas(255, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		send_meas(mk_meas(128, -1, 1, 32'sh00010000));
		send_meas(mk_meas(127, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f));
		send_meas(mk_meas(0, 32'sh00010000, 32'sh00020000, 32'sh00030000));
		send_meas(mk_meas(0, 32'sh00020000, 32'sh00040000, 32'sh00060000));
		send_meas(mk_meas(0, 32'sh00030000, 32'sh00060000, 32'sh00090000));
		for (int i = 0; i < 6; i++)
			send_meas(mk_meas(1, 32'sh7fffffff, 32'sh80000000, 0));
		send_meas(mk_meas(1, 32'sh80000000, 32'sh7fffffff, 0));
	endtask

	// mostly smooth trajectories per track, some raw noise items
	task automatic test_random(int n_items);
		int done, id, len, px, py, pz, vx, vy, vz;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(99) < 20) begin
				send_meas(mk_meas($urandom_range(255), $urandom, $urandom, $urandom));
				done++;
			end else begin
				id  = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15);
				len = $urandom_range(4, 20);
				px  = $signed($urandom_range(131072000)) - 65536000;
				py  = $signed($urandom_range(131072000)) - 65536000;
				pz  = $signed($urandom_range(13107200)) - 6553600;
				vx  = $signed($urandom_range(1310720)) - 655360;
				vy  = $signed($urandom_range(1310720)) - 655360;
				vz  = $signed($urandom_range(131072)) - 65536;
				for (int k = 0; k < len && done < n_items; k++) begin
					send_meas(mk_meas(id,
					                  px + $signed($urandom_range(65536)) - 32768,
					                  py + $signed($urandom_range(65536)) - 32768,
					                  pz + $signed($urandom_range(65536)) - 32768));
					px += qmul(flt_dt, vx);
					py += qmul(flt_dt, vy);
					pz += qmul(flt_dt, vz);
					done++;
				end
			end
		end
	endtask

	// output held off long enough that the block backs up onto its input
	task automatic test_backpressure();
		hold_cycles = 2000;
		for (int i = 0; i < 6; i++)
			send_meas(mk_meas($urandom_range(31), $urandom, $urandom, $urandom));
	endtask

	initial begin
		arst_n       = 1'b0;
		meas_valid   = 1'b0;
		meas         = '0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_TIME_STEP;
		cfg_data     = '0;
		hold_cycles  = 0;
		meas_idle_en = 1'b0;
		est_stall_en = 1'b0;
		n_sent = 0; n_checked = 0; n_errors = 0;
		flt_dt = 6554; flt_q = 6554; flt_r = 6554;
		for (int i = 0; i < MAX_TRACKS; i++)
			trk_live[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset, no idling: back-to-back stretch
		test_directed();
		test_random(150);
		drain();

		meas_idle_en = 1'b1;
		est_stall_en = 1'b1;
		set_filter(6554, 6554, 6554);
		test_random(450);
		test_backpressure();
		drain();

		// largest step, no process noise, smallest measurement noise
		set_filter(65536, 0, 1);
		test_directed();
		test_random(350);
		drain();

		// smallest step, largest noise terms
		set_filter(1, 65536, 65536);
		test_random(350);
		drain();

		// register values picked at random
		set_filter($urandom_range(1, 65536), $urandom_range(65536), $urandom_range(1, 65536));
		test_random(400);
		drain();

		$display("sent %0d measurements over five filter settings, %0d estimates checked",
		         n_sent, n_checked);
		$display("%0d mismatches, %0d estimates never returned", n_errors, est_q.size());
		if (n_errors == 0 && est_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[multi_track_kalman_filter.f]
src/mtkf_pkg.sv
src/multi_track_kalman_filter.sv
src/mtkf_checker.sv
verif/tb_top.sv
